// ----- rtl/core/gtc_pkg.sv -----
// shared types, register codes and constants of the generator transfer controller
package gtc_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_RUN_LIMIT      = 3'd0;
    localparam logic [2:0] REG_COOLDOWN_LIMIT = 3'd1;
    localparam logic [2:0] REG_TICKS_PER_SEC  = 3'd2;
    localparam logic [2:0] REG_CRANK_TRIES    = 3'd3;
    localparam logic [2:0] REG_CRANK_TICKS    = 3'd4;
    localparam logic [2:0] REG_OFF_PRE        = 3'd5;
    localparam logic [2:0] REG_OFF_SETTLE     = 3'd6;
    localparam logic [2:0] REG_MAINS_RETURN   = 3'd7;

    localparam logic [15:0] RUN_LIMIT_RST      = 16'd14388;
    localparam logic [15:0] COOLDOWN_LIMIT_RST = 16'd3599;
    localparam logic [7:0]  TICKS_PER_SEC_RST  = 8'd10;
    localparam logic [3:0]  CRANK_TRIES_RST    = 4'd5;
    localparam logic [7:0]  CRANK_TICKS_RST    = 8'd50;
    localparam logic [7:0]  OFF_PRE_RST        = 8'd20;
    localparam logic [7:0]  OFF_SETTLE_RST     = 8'd50;
    localparam logic [7:0]  MAINS_RETURN_RST   = 8'd20;

    localparam logic [7:0] POLL_WAIT_TICKS = 8'd10;
    localparam logic [7:0] STABILIZE_TICKS = 8'd50;

    // mode flag bits
    localparam int FLAG_AUTO  = 0;
    localparam int FLAG_RUN   = 1;
    localparam int FLAG_COOL  = 2;
    localparam int FLAG_FORCE = 3;

    // relay bits
    localparam int RELAY_STOP  = 0;
    localparam int RELAY_CHG   = 1;
    localparam int RELAY_START = 2;
    localparam int RELAY_ON    = 3;

    typedef enum logic [2:0] {
        PH_SCAN    = 3'd0,
        PH_POLL    = 3'd1,
        PH_CRANK   = 3'd2,
        PH_STAB    = 3'd3,
        PH_MAINS   = 3'd4,
        PH_OFFPRE  = 3'd5,
        PH_OFFSETL = 3'd6
    } phase_t;

    typedef struct packed {
        logic [15:0] run_limit;
        logic [15:0] cooldown_limit;
        logic [7:0]  ticks_per_second;
        logic [3:0]  crank_tries;
        logic [7:0]  crank_ticks;
        logic [7:0]  off_pre_ticks;
        logic [7:0]  off_settle_ticks;
        logic [7:0]  mains_return_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] relays;
        logic [3:0] flags;
        phase_t     phase;
    } status_t;

endpackage

// ----- rtl/core/gtc_cfg.sv -----
// configuration register file behind the apb-style port
module gtc_cfg
    import gtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_limit          <= RUN_LIMIT_RST;
            cfg_reg.cooldown_limit     <= COOLDOWN_LIMIT_RST;
            cfg_reg.ticks_per_second   <= TICKS_PER_SEC_RST;
            cfg_reg.crank_tries        <= CRANK_TRIES_RST;
            cfg_reg.crank_ticks        <= CRANK_TICKS_RST;
            cfg_reg.off_pre_ticks      <= OFF_PRE_RST;
            cfg_reg.off_settle_ticks   <= OFF_SETTLE_RST;
            cfg_reg.mains_return_ticks <= MAINS_RETURN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RUN_LIMIT:      cfg_reg.run_limit          <= pwdata[15:0];
                REG_COOLDOWN_LIMIT: cfg_reg.cooldown_limit     <= pwdata[15:0];
                REG_TICKS_PER_SEC:  cfg_reg.ticks_per_second   <= pwdata[7:0];
                REG_CRANK_TRIES:    cfg_reg.crank_tries        <= pwdata[3:0];
                REG_CRANK_TICKS:    cfg_reg.crank_ticks        <= pwdata[7:0];
                REG_OFF_PRE:        cfg_reg.off_pre_ticks      <= pwdata[7:0];
                REG_OFF_SETTLE:     cfg_reg.off_settle_ticks   <= pwdata[7:0];
                REG_MAINS_RETURN:   cfg_reg.mains_return_ticks <= pwdata[7:0];
                default:            cfg_reg.run_limit          <= cfg_reg.run_limit;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_RUN_LIMIT:      prdata[15:0] = cfg_reg.run_limit;
            REG_COOLDOWN_LIMIT: prdata[15:0] = cfg_reg.cooldown_limit;
            REG_TICKS_PER_SEC:  prdata[7:0]  = cfg_reg.ticks_per_second;
            REG_CRANK_TRIES:    prdata[3:0]  = cfg_reg.crank_tries;
            REG_CRANK_TICKS:    prdata[7:0]  = cfg_reg.crank_ticks;
            REG_OFF_PRE:        prdata[7:0]  = cfg_reg.off_pre_ticks;
            REG_OFF_SETTLE:     prdata[7:0]  = cfg_reg.off_settle_ticks;
            REG_MAINS_RETURN:   prdata[7:0]  = cfg_reg.mains_return_ticks;
            default:            prdata       = '0;
        endcase
    end

endmodule

// ----- rtl/core/gtc_step.sv -----
// controller state registers and the per-tick next-state logic
module gtc_step
    import gtc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_en,
    input  logic    off_button,
    input  logic    start_button,
    input  logic    auto_button,
    input  logic    mains_present,
    input  logic    gen_running,
    input  cfg_t    cfg,
    output status_t status
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [7:0]            wait_reg, wait_next;
    logic [7:0]            tick_reg, tick_next;
    logic [TIMER_BITS-1:0] run_sec_reg, run_sec_next;
    logic [TIMER_BITS-1:0] cool_sec_reg, cool_sec_next;
    logic [3:0]            tries_reg, tries_next;
    logic [3:0]            flags_reg, flags_next;
    logic [3:0]            relays_reg, relays_next;
    logic                  last_off_reg, last_off_next;

    logic [7:0]            tps;
    logic [7:0]            wait_dec;
    logic                  wait_done;
    logic                  gave_up;
    logic                  to_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCAN;
            wait_reg     <= '0;
            tick_reg     <= '0;
            run_sec_reg  <= '0;
            cool_sec_reg <= '0;
            tries_reg    <= '0;
            flags_reg    <= '0;
            relays_reg   <= '0;
            last_off_reg <= 1'b0;
        end
        else if (tick_en)
        begin
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            tick_reg     <= tick_next;
            run_sec_reg  <= run_sec_next;
            cool_sec_reg <= cool_sec_next;
            tries_reg    <= tries_next;
            flags_reg    <= flags_next;
            relays_reg   <= relays_next;
            last_off_reg <= last_off_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        tick_next     = tick_reg + 8'd1;
        run_sec_next  = run_sec_reg;
        cool_sec_next = cool_sec_reg;
        tries_next    = tries_reg;
        flags_next    = flags_reg;
        relays_next   = relays_reg;
        gave_up       = 1'b0;
        tps           = (cfg.ticks_per_second == 8'd0) ? 8'd1 : cfg.ticks_per_second;

        // seconds prescaler and run / cooldown timers
        if (tick_next >= tps)
        begin
            tick_next = '0;
            if (CMP_W'(run_sec_next) == CMP_W'(cfg.run_limit))
            begin
                run_sec_next          = '0;
                flags_next[FLAG_RUN]  = 1'b0;
                flags_next[FLAG_COOL] = 1'b1;
            end
            if (CMP_W'(cool_sec_next) == CMP_W'(cfg.cooldown_limit))
            begin
                cool_sec_next         = '0;
                flags_next[FLAG_COOL] = 1'b0;
            end
            if (flags_next[FLAG_RUN] && gen_running && run_sec_next != TIMER_MAX)
                run_sec_next = run_sec_next + 1'b1;
            if (flags_next[FLAG_COOL] && cool_sec_next != TIMER_MAX)
                cool_sec_next = cool_sec_next + 1'b1;
        end

        // rising off edge aborts whatever is going on
        if (off_button && !last_off_reg)
        begin
            flags_next[FLAG_AUTO]  = 1'b0;
            flags_next[FLAG_RUN]   = 1'b0;
            flags_next[FLAG_FORCE] = 1'b1;
            tries_next             = '0;
            phase_next             = PH_SCAN;
            wait_next              = '0;
        end
        last_off_next = off_button;

        wait_dec  = (wait_next != 8'd0) ? wait_next - 8'd1 : wait_next;
        wait_done = (wait_dec == 8'd0);
        to_off    = flags_next[FLAG_FORCE] || off_button ||
                    (!flags_next[FLAG_RUN] && flags_next[FLAG_COOL]);

        unique case (phase_next)
            PH_SCAN:
            begin
                if (to_off)
                begin
                    flags_next[FLAG_AUTO] = 1'b0;
                    phase_next            = PH_OFFPRE;
                    wait_next             = cfg.off_pre_ticks;
                end
                else if (auto_button)
                begin
                    flags_next[FLAG_AUTO] = 1'b1;
                    if (mains_present)
                    begin
                        phase_next = PH_MAINS;
                        wait_next  = cfg.mains_return_ticks;
                    end
                    else
                    begin
                        phase_next = PH_POLL;
                        wait_next  = POLL_WAIT_TICKS;
                    end
                end
                else if (start_button)
                begin
                    flags_next[FLAG_AUTO]    = 1'b0;
                    flags_next[FLAG_RUN]     = 1'b1;
                    relays_next[RELAY_STOP]  = 1'b1;
                    relays_next[RELAY_ON]    = 1'b1;
                    relays_next[RELAY_START] = 1'b1;
                end
                else
                begin
                    relays_next[RELAY_START] = 1'b0;
                    flags_next[FLAG_AUTO]    = 1'b0;
                end
            end
            PH_POLL:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    if (!flags_next[FLAG_RUN] && !flags_next[FLAG_COOL])
                    begin
                        relays_next[RELAY_STOP] = 1'b1;
                        relays_next[RELAY_ON]   = 1'b1;
                        tries_next              = '0;
                        if (!gen_running && (4'd0 < cfg.crank_tries))
                        begin
                            relays_next[RELAY_START] = 1'b1;
                            phase_next               = PH_CRANK;
                            wait_next                = cfg.crank_ticks;
                        end
                        else
                        begin
                            phase_next = PH_STAB;
                            wait_next  = STABILIZE_TICKS;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SCAN;
                        wait_next  = '0;
                    end
                end
            end
            PH_CRANK:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    tries_next = tries_next + 4'd1;
                    if (tries_next == cfg.crank_tries)
                    begin
                        tries_next             = '0;
                        relays_next            = '0;
                        flags_next[FLAG_RUN]   = 1'b0;
                        flags_next[FLAG_FORCE] = 1'b1;
                        gave_up                = 1'b1;
                    end
                    else
                    begin
                        flags_next[FLAG_RUN] = 1'b1;
                    end
                    relays_next[RELAY_START] = 1'b0;
                    if (!gave_up && !gen_running && (tries_next < cfg.crank_tries))
                    begin
                        relays_next[RELAY_START] = 1'b1;
                        phase_next               = PH_CRANK;
                        wait_next                = cfg.crank_ticks;
                    end
                    else
                    begin
                        phase_next = PH_STAB;
                        wait_next  = STABILIZE_TICKS;
                    end
                end
            end
            PH_STAB:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    if (!mains_present && flags_next[FLAG_RUN])
                        relays_next[RELAY_CHG] = 1'b1;
                    phase_next = PH_SCAN;
                    wait_next  = '0;
                end
            end
            PH_MAINS:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    relays_next[RELAY_CHG] = 1'b0;
                    flags_next[FLAG_FORCE] = 1'b1;
                    phase_next             = PH_SCAN;
                    wait_next              = '0;
                end
            end
            PH_OFFPRE:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    relays_next = '0;
                    phase_next  = PH_OFFSETL;
                    wait_next   = cfg.off_settle_ticks;
                end
            end
            PH_OFFSETL:
            begin
                wait_next = wait_dec;
                if (wait_done)
                begin
                    if (!gen_running)
                        flags_next[FLAG_RUN] = 1'b0;
                    flags_next[FLAG_FORCE] = 1'b0;
                    phase_next             = PH_SCAN;
                    wait_next              = '0;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
                wait_next  = '0;
            end
        endcase
    end

    assign status.relays = relays_reg;
    assign status.flags  = flags_reg;
    assign status.phase  = phase_reg;

endmodule

// ----- rtl/core/generator_transfer_controller.sv -----
// generator transfer controller top level: handshake, config port and tick controller
// Each input beat is one sampled 100 ms tick; the controller handles it and the result
// beat appears on the next cycle, so one beat per clock is sustained while out_stall is
// low. The state registers double as the result register: a new tick is taken whenever
// no result is waiting or the waiting one is taken in the same cycle, which makes
// in_stall follow out_stall while a result is held. Configuration is written through the
// apb-style port at byte address 4 * register index and takes effect on the next tick.
module generator_transfer_controller
    import gtc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  off_button,
    input  logic                  start_button,
    input  logic                  auto_button,
    input  logic                  mains_present,
    input  logic                  gen_running,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  stop_relay,
    output logic                  changeover_relay,
    output logic                  start_relay,
    output logic                  on_relay,
    output logic                  auto_mode,
    output logic                  run_active,
    output logic                  cooling,
    output logic [2:0]            phase
);

    cfg_t    cfg;
    status_t status;
    logic    in_acc;
    logic    out_valid_reg, out_valid_next;

    gtc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (in_acc),
        .off_button    (off_button),
        .start_button  (start_button),
        .auto_button   (auto_button),
        .mains_present (mains_present),
        .gen_running   (gen_running),
        .cfg           (cfg),
        .status        (status)
    );

    // result slot is free when empty or drained this cycle
    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;

    always_comb
    begin
        if (in_acc)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid        = out_valid_reg;
    assign stop_relay       = status.relays[RELAY_STOP];
    assign changeover_relay = status.relays[RELAY_CHG];
    assign start_relay      = status.relays[RELAY_START];
    assign on_relay         = status.relays[RELAY_ON];
    assign auto_mode        = status.flags[FLAG_AUTO];
    assign run_active       = status.flags[FLAG_RUN];
    assign cooling          = status.flags[FLAG_COOL];
    assign phase            = status.phase;

endmodule
